FILE: design/gpio_rb_pkg.sv
`timescale 1ns / 1ps

package gpio_rb_pkg;

   localparam int NUM_PINS_DEFAULT = 54;
   localparam int OUT_W            = 54;
   localparam int DATA_W           = 32;
   localparam int OFS_W            = 6;
   localparam int WIDE_W           = 64;

   // function select packing
   localparam int PINS_PER_FSEL = 10;
   localparam int FSEL_BITS     = 3;
   localparam int FSEL_WORDS    = 6;

   localparam logic [2:0] FSEL_OUTPUT = 3'b001;
   localparam logic [1:0] PULL_DOWN   = 2'd1;
   localparam logic [1:0] PULL_UP     = 2'd2;

   localparam logic REQ_READ  = 1'b0;
   localparam logic REQ_WRITE = 1'b1;

   // register word offsets
   localparam logic [5:0] OFS_FSEL_LAST = 6'd5;
   localparam logic [5:0] OFS_SET0      = 6'd7;
   localparam logic [5:0] OFS_SET1      = 6'd8;
   localparam logic [5:0] OFS_CLR0      = 6'd10;
   localparam logic [5:0] OFS_CLR1      = 6'd11;
   localparam logic [5:0] OFS_LEV0      = 6'd13;
   localparam logic [5:0] OFS_LEV1      = 6'd14;
   localparam logic [5:0] OFS_PUD       = 6'd37;
   localparam logic [5:0] OFS_PUDCLK0   = 6'd38;
   localparam logic [5:0] OFS_PUDCLK1   = 6'd39;

   typedef struct packed {
      logic              req_type;
      logic [OFS_W-1:0]  word_offset;
      logic [DATA_W-1:0] write_data;
      logic [OUT_W-1:0]  pin_levels;
   } req_payload_type;

   typedef struct packed {
      logic [DATA_W-1:0] read_data;
      logic [OUT_W-1:0]  pin_drive;
      logic [OUT_W-1:0]  pin_output_enable;
      logic [OUT_W-1:0]  pull_up_mask;
      logic [OUT_W-1:0]  pull_down_mask;
   } rsp_payload_type;

endpackage

FILE: design/gpio_rb_regs.sv
`timescale 1ns / 1ps

module gpio_rb_regs #(
   parameter int NUM_PINS = gpio_rb_pkg::NUM_PINS_DEFAULT
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        accept,
   input  gpio_rb_pkg::req_payload_type req,
   output gpio_rb_pkg::rsp_payload_type result
);
   import gpio_rb_pkg::*;

   localparam int P = NUM_PINS;

   logic [2:0]   fsel_ff [P];
   logic [2:0]   fsel_in [P];
   logic [1:0]   mode_ff [P];
   logic [1:0]   mode_in [P];
   logic [P-1:0] latch_ff, latch_in;
   logic [1:0]   pullctl_ff, pullctl_in;

   logic                wr;
   logic [OFS_W-1:0]    off;
   logic [DATA_W-1:0]   wdata;
   logic [P-1:0]        ext;
   logic [P-1:0]        oe_now, oe_in, up_in, down_in, level, clk_sel;
   logic [WIDE_W-1:0]   level_wide;
   logic [DATA_W-1:0]   fsel_word [FSEL_WORDS];
   logic [DATA_W-1:0]   rd;

   // place a data word at pin 0 or pin 32, keeping only existing pins
   function automatic logic [P-1:0] spread(input logic [DATA_W-1:0] d, input logic half);
      logic [WIDE_W-1:0] v;
      v = half ? {d, 32'b0} : {32'b0, d};
      return v[P-1:0];
   endfunction

   function automatic logic [OUT_W-1:0] to_out(input logic [P-1:0] v);
      logic [WIDE_W-1:0] w;
      w = WIDE_W'(v);
      return w[OUT_W-1:0];
   endfunction

   assign wr    = accept && (req.req_type == REQ_WRITE);
   assign off   = req.word_offset;
   assign wdata = req.write_data;

   always_comb begin
      logic [WIDE_W-1:0] ext_wide;
      ext_wide = WIDE_W'(req.pin_levels);
      ext      = ext_wide[P-1:0];
   end

   // next state
   always_comb begin
      latch_in   = latch_ff;
      pullctl_in = pullctl_ff;
      clk_sel    = '0;
      if (wr) begin
         priority if (off == OFS_SET0 || off == OFS_SET1) begin
            latch_in = latch_ff | spread(wdata, off == OFS_SET1);
         end else if (off == OFS_CLR0 || off == OFS_CLR1) begin
            latch_in = latch_ff & ~spread(wdata, off == OFS_CLR1);
         end else if (off == OFS_PUD) begin
            pullctl_in = wdata[1:0];
         end else if (off == OFS_PUDCLK0 || off == OFS_PUDCLK1) begin
            clk_sel = spread(wdata, off == OFS_PUDCLK1);
         end else begin
         end
      end
      for (int p = 0; p < P; p++) begin
         fsel_in[p] = fsel_ff[p];
         if (wr && off <= OFS_FSEL_LAST && off == OFS_W'(p / PINS_PER_FSEL)) begin
            fsel_in[p] = wdata[FSEL_BITS * (p % PINS_PER_FSEL) +: FSEL_BITS];
         end
         mode_in[p] = clk_sel[p] ? pullctl_ff : mode_ff[p];
      end
   end

   // per-pin decode
   always_comb begin
      for (int p = 0; p < P; p++) begin
         oe_now[p]  = (fsel_ff[p] == FSEL_OUTPUT);
         oe_in[p]   = (fsel_in[p] == FSEL_OUTPUT);
         up_in[p]   = (mode_in[p] == PULL_UP);
         down_in[p] = (mode_in[p] == PULL_DOWN);
      end
   end

   always_comb begin
      for (int w = 0; w < FSEL_WORDS; w++) begin
         fsel_word[w] = '0;
         for (int k = 0; k < PINS_PER_FSEL; k++) begin
            if (w * PINS_PER_FSEL + k < P) begin
               fsel_word[w][FSEL_BITS * k +: FSEL_BITS] = fsel_ff[w * PINS_PER_FSEL + k];
            end
         end
      end
   end

   assign level      = (latch_ff & oe_now) | (ext & ~oe_now);
   assign level_wide = WIDE_W'(level);

   always_comb begin
      rd = '0;
      if (req.req_type == REQ_READ) begin
         priority if (off <= OFS_FSEL_LAST) begin
            rd = fsel_word[off[2:0]];
         end else if (off == OFS_LEV0) begin
            rd = level_wide[31:0];
         end else if (off == OFS_LEV1) begin
            rd = level_wide[63:32];
         end else if (off == OFS_PUD) begin
            rd = DATA_W'(pullctl_ff);
         end else begin
            rd = '0;
         end
      end
   end

   always_comb begin
      result.read_data         = rd;
      result.pin_drive         = to_out(latch_in);
      result.pin_output_enable = to_out(oe_in);
      result.pull_up_mask      = to_out(up_in);
      result.pull_down_mask    = to_out(down_in);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         latch_ff   <= '0;
         pullctl_ff <= '0;
         for (int p = 0; p < P; p++) begin
            fsel_ff[p] <= '0;
            mode_ff[p] <= '0;
         end
      end else if (accept) begin
         latch_ff   <= latch_in;
         pullctl_ff <= pullctl_in;
         for (int p = 0; p < P; p++) begin
            fsel_ff[p] <= fsel_in[p];
            mode_ff[p] <= mode_in[p];
         end
      end
   end

endmodule

FILE: design/gpio_rb_outbuf.sv
`timescale 1ns / 1ps

module gpio_rb_outbuf (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         in_valid,
   output logic                         in_stall,
   input  gpio_rb_pkg::rsp_payload_type in_data,
   output logic                         out_valid,
   input  logic                         out_stall,
   output gpio_rb_pkg::rsp_payload_type out_data
);
   import gpio_rb_pkg::*;

   rsp_payload_type main_ff, skid_ff;
   logic            main_valid_ff, skid_valid_ff;
   logic            push, take;

   assign in_stall  = skid_valid_ff;
   assign push      = in_valid && !skid_valid_ff;
   assign take      = main_valid_ff && !out_stall;
   assign out_valid = main_valid_ff;
   assign out_data  = main_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         main_valid_ff <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (skid_valid_ff) begin
         if (take) begin
            main_ff       <= skid_ff;
            skid_valid_ff <= 1'b0;
         end
      end else if (push) begin
         if (!main_valid_ff || take) begin
            main_ff       <= in_data;
            main_valid_ff <= 1'b1;
         end else begin
            skid_ff       <= in_data;
            skid_valid_ff <= 1'b1;
         end
      end else if (take) begin
         main_valid_ff <= 1'b0;
      end
   end

endmodule

FILE: design/gpio_register_block_core.sv
`timescale 1ns / 1ps

// GPIO register block: one bus transaction in, one result transaction out. Each request is a
// read or write at a 32-bit word offset (function select 0-5, latch set 7-8, latch clear
// 10-11, pin level 13-14, pull mode 37, pull clock 38-39; everything else reads zero). The
// result carries the read data (zero on writes) and a snapshot of the pin outputs taken after
// the access: output latch, output enables and the pull-up/pull-down masks. Register state is
// updated in the cycle a request is accepted and the result lands in the output register, so
// with the result side taking every cycle one transaction goes through per clock. A two-entry
// output buffer lets one more request in while a result waits; the request side stalls only
// when both entries are full.

module gpio_register_block_core #(
   parameter int NUM_PINS = gpio_rb_pkg::NUM_PINS_DEFAULT
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_stall,
   input  gpio_rb_pkg::req_payload_type req_payload,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output gpio_rb_pkg::rsp_payload_type rsp_payload
);
   import gpio_rb_pkg::*;

   logic            req_accept;
   rsp_payload_type result;

   // a request is taken whenever the output buffer has room
   assign req_accept = req_valid && !req_stall;

   // register file and access decode
   gpio_rb_regs #(
      .NUM_PINS (NUM_PINS)
   ) u_regs (
      .clock  (clock),
      .reset  (reset),
      .accept (req_accept),
      .req    (req_payload),
      .result (result)
   );

   // result register plus skid entry
   gpio_rb_outbuf u_outbuf (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_valid),
      .in_stall  (req_stall),
      .in_data   (result),
      .out_valid (rsp_valid),
      .out_stall (rsp_stall),
      .out_data  (rsp_payload)
   );

   // skid entry only fills behind a waiting result
   assert property (@(posedge clock) disable iff (reset) req_stall |-> rsp_valid)
      else $error("request stalled with no result pending");

   // a transaction into an empty buffer shows up as a result next cycle
   assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall && !rsp_valid) |=> rsp_valid)
      else $error("accepted transaction did not reach the result register");

   // a pin cannot be pulled up and down at once
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ((rsp_payload.pull_up_mask & rsp_payload.pull_down_mask) == '0))
      else $error("pull-up and pull-down masks overlap");

endmodule
